>>> rtl/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

    localparam int MAX_PAGE_W  = 32;
    localparam int MAX_IDX_W   = 6;
    localparam int CNT_W       = 7;
    localparam int AGE_W       = 16;
    localparam int FAULT_W     = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int OUT_FRAME_W = 3;

    localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 4'd4;

    typedef struct packed {
        logic                  valid;
        logic [MAX_PAGE_W-1:0] page;
        logic                  hit_found;
        logic [MAX_IDX_W-1:0]  hit_idx;
        logic                  empty_found;
        logic [MAX_IDX_W-1:0]  empty_idx;
        logic [AGE_W-1:0]      max_age;
        logic [MAX_IDX_W-1:0]  max_idx;
        logic [MAX_PAGE_W-1:0] max_page;
    } t_probe;

    typedef struct packed {
        logic                  en;
        logic [MAX_IDX_W-1:0]  slot;
        logic                  load;
        logic                  clear_age;
        logic [MAX_PAGE_W-1:0] page;
    } t_update;

endpackage

`default_nettype wire

>>> rtl/pfr_cell.sv
`default_nettype none

module pfr_cell #(
    parameter int PAGE_BITS = 16,
    parameter int IDX       = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire pfr_pkg::t_probe       i_probe,
    input  wire pfr_pkg::t_update      i_upd,
    input  wire logic [pfr_pkg::CNT_W-1:0] i_count,
    output pfr_pkg::t_probe            o_probe
);
    import pfr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [AGE_W-1:0]     r_age;
    t_probe               r_probe;
    t_probe               n_probe;

    logic active;
    logic match;
    logic sel;

    always_comb begin
        active  = i_probe.valid && (CNT_W'(IDX) < i_count);
        match   = r_valid && (r_page == i_probe.page[PAGE_BITS-1:0]);
        sel     = (i_upd.slot == MAX_IDX_W'(IDX));
        n_probe = i_probe;
        if (active) begin
            if (!i_probe.hit_found && match) begin
                n_probe.hit_found = 1'b1;
                n_probe.hit_idx   = MAX_IDX_W'(IDX);
            end
            if (!i_probe.empty_found && !r_valid) begin
                n_probe.empty_found = 1'b1;
                n_probe.empty_idx   = MAX_IDX_W'(IDX);
            end
            if (r_age >= i_probe.max_age) begin
                n_probe.max_age  = r_age;
                n_probe.max_idx  = MAX_IDX_W'(IDX);
                n_probe.max_page = MAX_PAGE_W'(r_page);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page  <= '0;
            r_valid <= 1'b0;
            r_age   <= '0;
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
            if (i_upd.en) begin
                if (sel && i_upd.load) begin
                    r_page  <= i_upd.page[PAGE_BITS-1:0];
                    r_valid <= 1'b1;
                end
                if (sel && i_upd.clear_age) begin
                    r_age <= AGE_W'(1);
                end else if (r_age != AGE_MAX) begin
                    r_age <= r_age + AGE_W'(1);
                end
            end
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

>>> rtl/pfr_ctrl.sv
`default_nettype none

module pfr_ctrl #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [PAGE_BITS-1:0]             i_page_number,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire pfr_pkg::t_probe                  i_tail,
    output pfr_pkg::t_probe                       o_launch,
    output pfr_pkg::t_update                      o_upd,
    output logic [pfr_pkg::CNT_W-1:0]             o_count,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_hit,
    output logic [pfr_pkg::OUT_FRAME_W-1:0]       o_frame_index,
    output logic                                  o_evicted_valid,
    output logic [PAGE_BITS-1:0]                  o_evicted_page,
    output logic [pfr_pkg::FAULT_W-1:0]           o_fault_total
);
    import pfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_policy;
    logic [CFG_DATA_W-1:0] r_frames;
    logic [FAULT_W-1:0]    r_fault;
    logic [FAULT_W-1:0]    n_fault;
    t_probe                r_tail;
    t_probe                r_launch;
    t_probe                n_launch;
    logic                  r_out_valid;
    logic                  r_hit;
    logic [OUT_FRAME_W-1:0] r_frame_index;
    logic                  r_ev_valid;
    logic [PAGE_BITS-1:0]  r_ev_page;

    logic                  accept;
    logic                  out_free;
    logic [CNT_W-1:0]      frames_ext;
    logic [MAX_IDX_W-1:0]  slot;
    logic                  ev_valid;
    t_update               upd;

    always_comb begin
        frames_ext = CNT_W'(r_frames);
        if (r_frames == '0) begin
            o_count = CNT_W'(1);
        end else if (frames_ext > CNT_W'(FRAMES)) begin
            o_count = CNT_W'(FRAMES);
        end else begin
            o_count = frames_ext;
        end
    end

    always_comb begin
        accept   = i_in_valid && (r_state == S_IDLE);
        out_free = !r_out_valid || !i_out_stall;

        n_launch          = '0;
        n_launch.valid    = accept;
        n_launch.page     = MAX_PAGE_W'(i_page_number);

        ev_valid = !r_tail.hit_found && !r_tail.empty_found;
        if (r_tail.hit_found) begin
            slot = r_tail.hit_idx;
        end else if (r_tail.empty_found) begin
            slot = r_tail.empty_idx;
        end else begin
            slot = r_tail.max_idx;
        end

        n_fault = r_fault;
        if (!r_tail.hit_found && (r_fault != FAULT_MAX)) begin
            n_fault = r_fault + FAULT_W'(1);
        end

        upd.en        = (r_state == S_DONE) && out_free;
        upd.slot      = slot;
        upd.load      = !r_tail.hit_found;
        upd.clear_age = !r_tail.hit_found || (r_policy == POLICY_LRU);
        upd.page      = r_tail.page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_policy      <= POLICY_FIFO;
            r_frames      <= FRAMES_RESET;
            r_fault       <= '0;
            r_tail        <= '0;
            r_launch      <= '0;
            r_out_valid   <= 1'b0;
            r_hit         <= 1'b0;
            r_frame_index <= '0;
            r_ev_valid    <= 1'b0;
            r_ev_page     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_POLICY: r_policy <= i_cfg_wdata[0];
                    CFG_FRAMES: r_frames <= i_cfg_wdata;
                endcase
            end

            r_launch <= n_launch;

            if (r_out_valid && !i_out_stall && !upd.en) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_tail.valid) begin
                        r_tail  <= i_tail;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_fault       <= n_fault;
                        r_out_valid   <= 1'b1;
                        r_hit         <= r_tail.hit_found;
                        r_frame_index <= slot[OUT_FRAME_W-1:0];
                        r_ev_valid    <= ev_valid;
                        r_ev_page     <= ev_valid ? r_tail.max_page[PAGE_BITS-1:0] : '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_launch        = r_launch;
    assign o_upd           = upd;
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame_index   = r_frame_index;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault;

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tail.valid |-> (r_state == S_SCAN))
        else $error("probe left the chain outside a scan");

    a_slot_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.en |-> (CNT_W'(upd.slot) < o_count))
        else $error("update targets a frame outside the active set");

    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fault >= $past(r_fault)))
        else $error("fault count went backwards");

    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.en |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("frame update without a result");

endmodule

`default_nettype wire

>>> rtl/page_frame_replacement_unit.sv
`default_nettype none
// Requests are taken one at a time: o_in_stall holds off input from an accepted request
// until its result is registered; the lookup probe walks the frame chain one cell per cycle,
// then, once the output is free, the chosen frame is updated and the other ages advance.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous and active low; it empties all frames, clears ages and the fault
// count, and sets FIFO policy with four active frames.

module page_frame_replacement_unit #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [PAGE_BITS-1:0]             i_page_number,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_hit,
    output logic [pfr_pkg::OUT_FRAME_W-1:0]       o_frame_index,
    output logic                                  o_evicted_valid,
    output logic [PAGE_BITS-1:0]                  o_evicted_page,
    output logic [pfr_pkg::FAULT_W-1:0]           o_fault_total
);
    import pfr_pkg::*;

    t_probe           chain [FRAMES+1];
    t_update          upd;
    logic [CNT_W-1:0] count;
    logic [FRAMES:0]  probe_valids;

    pfr_ctrl #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_tail          (chain[FRAMES]),
        .o_launch        (chain[0]),
        .o_upd           (upd),
        .o_count         (count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

    for (genvar k = 0; k < FRAMES; k++) begin : g_cell
        pfr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .IDX       (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (chain[k]),
            .i_upd   (upd),
            .i_count (count),
            .o_probe (chain[k+1])
        );
    end

    always_comb begin
        for (int k = 0; k <= FRAMES; k++) begin
            probe_valids[k] = chain[k].valid;
        end
    end

    a_single_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(probe_valids))
        else $error("more than one probe in the frame chain");

    a_no_probe_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd.en |-> (probe_valids == '0))
        else $error("frame update while a probe is in the chain");

    a_stall_while_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (probe_valids != '0) |-> o_in_stall)
        else $error("request taken while a lookup is in progress");

endmodule

`default_nettype wire
